FILE: rtl/eqo_pkg.sv
// ----------------------------------------------------------------------------
// eqo_pkg
// Shared constants, widths and types of the ellipse quadrature oscillator.
// ----------------------------------------------------------------------------
package eqo_pkg;

  localparam int PHASE_BITS_DEF  = 16;
  localparam int SAMPLE_BITS_DEF = 16;

  // angles in turn units, 2^32 per turn, wide enough for one extra quarter
  localparam int ANG_W = 34;
  localparam logic signed [ANG_W-1:0] TURN         = 34'sd4294967296;
  localparam logic signed [ANG_W-1:0] HALF_TURN    = 34'sd2147483648;
  localparam logic signed [ANG_W-1:0] QUARTER_TURN = 34'sd1073741824;

  // polynomial constants, Q28
  localparam logic [30:0] TWO_PI_Q28 = 31'd1686629713;
  localparam logic [25:0] K_SIX      = 26'd44739243;
  localparam logic [21:0] K_120      = 22'd2236962;
  localparam logic [15:0] K_5040     = 16'd53261;
  localparam logic [28:0] Q28_ONE    = 29'd268435456;

  localparam int SIN_W   = 32;  // signed Q28 sine
  localparam int SIN_LAT = 13;  // register stages of the sine unit
  localparam int MAG_W   = 30;  // magnitude of the Q24 vector components
  localparam int V_W     = 58;  // squared length
  localparam int R_W     = V_W / 2;
  localparam int NUM_W   = 60;  // signed projection numerator
  localparam int Q_W     = 31;  // quotient bits
  localparam int RAT_W   = 29;  // saturated ratio magnitude

  typedef enum logic [2:0] {
    IDX_LEVEL_GAIN = 3'd0,
    IDX_X_OFFSET   = 3'd1,
    IDX_Y_OFFSET   = 3'd2,
    IDX_X_SCALE    = 3'd3,
    IDX_Y_SCALE    = 3'd4,
    IDX_X_SHAPE    = 3'd5,
    IDX_Y_SHAPE    = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] level;
    logic [15:0] offset;
    logic [15:0] scale;
    logic [15:0] shape;
  } chan_cfg_t;

endpackage

FILE: rtl/eqo_sin.sv
// ----------------------------------------------------------------------------
// eqo_sin
// Pipelined sine of a turn-unit angle: wrap, radian conversion and the
// seventh-order odd polynomial, one wrap, multiply or rounding per stage.
// ----------------------------------------------------------------------------
module eqo_sin (
  input  logic                             clk,
  input  logic signed [eqo_pkg::ANG_W-1:0] in_angle,
  output logic signed [eqo_pkg::SIN_W-1:0] out_sin
);

  localparam logic [62:0] RND31 = 63'd2147483648;

  logic signed [eqo_pkg::ANG_W-1:0] wrap_nxt;
  logic signed [eqo_pkg::ANG_W-1:0] amag_nxt;
  logic [31:0] r5_nxt;
  logic signed [32:0] t3_nxt;
  logic [32:0] t3m_nxt;
  logic [31:0] r6_nxt;

  logic [31:0] m1_r;
  logic [62:0] p1_r;
  logic [29:0] xr3_r, xr4_r, xr5_r, xr6_r, xr7_r, xr8_r, xr9_r, xr10_r, xr11_r;
  logic [59:0] p2_r;
  logic [31:0] x2_5_r, x2_6_r, x2_7_r, x2_8_r, x2_9_r;
  logic [47:0] p3_r;
  logic [21:0] t1_7_r;
  logic [53:0] p4_r;
  logic [25:0] t2m_9_r;
  logic [57:0] p5_r;
  logic [31:0] t3m_11_r;
  logic        t3n_11_r;
  logic [61:0] p6_r;
  logic        sg12_r;
  logic n1_r, n2_r, n3_r, n4_r, n5_r, n6_r, n7_r, n8_r, n9_r, n10_r, n11_r;

  always_comb begin
    wrap_nxt = in_angle;
    if (in_angle > eqo_pkg::HALF_TURN) begin
      wrap_nxt = in_angle - eqo_pkg::TURN;
    end else if (in_angle < -eqo_pkg::HALF_TURN) begin
      wrap_nxt = in_angle + eqo_pkg::TURN;
    end
    amag_nxt = wrap_nxt[eqo_pkg::ANG_W-1] ? -wrap_nxt : wrap_nxt;
    r5_nxt   = 32'((p5_r + 58'd134217728) >> 28);
    t3_nxt   = 33'sd268435456 - $signed({1'b0, r5_nxt});
    t3m_nxt  = t3_nxt[32] ? 33'(-t3_nxt) : 33'(t3_nxt);
    r6_nxt   = 32'((p6_r + 62'd134217728) >> 28);
  end

  always_ff @(posedge clk) begin
    m1_r     <= amag_nxt[31:0];
    n1_r     <= wrap_nxt[eqo_pkg::ANG_W-1];
    p1_r     <= 63'(m1_r) * 63'(eqo_pkg::TWO_PI_Q28);
    n2_r     <= n1_r;
    xr3_r    <= 30'((p1_r + RND31) >> 32);
    n3_r     <= n2_r;
    p2_r     <= 60'(xr3_r) * 60'(xr3_r);
    xr4_r    <= xr3_r;
    n4_r     <= n3_r;
    x2_5_r   <= 32'((p2_r + 60'd134217728) >> 28);
    xr5_r    <= xr4_r;
    n5_r     <= n4_r;
    p3_r     <= 48'(x2_5_r) * 48'(eqo_pkg::K_5040);
    x2_6_r   <= x2_5_r;
    xr6_r    <= xr5_r;
    n6_r     <= n5_r;
    t1_7_r   <= 22'(48'(eqo_pkg::K_120) - ((p3_r + 48'd134217728) >> 28));
    x2_7_r   <= x2_6_r;
    xr7_r    <= xr6_r;
    n7_r     <= n6_r;
    p4_r     <= 54'(x2_7_r) * 54'(t1_7_r);
    x2_8_r   <= x2_7_r;
    xr8_r    <= xr7_r;
    n8_r     <= n7_r;
    t2m_9_r  <= 26'(54'(eqo_pkg::K_SIX) - ((p4_r + 54'd134217728) >> 28));
    x2_9_r   <= x2_8_r;
    xr9_r    <= xr8_r;
    n9_r     <= n8_r;
    p5_r     <= 58'(x2_9_r) * 58'(t2m_9_r);
    xr10_r   <= xr9_r;
    n10_r    <= n9_r;
    t3m_11_r <= t3m_nxt[31:0];
    t3n_11_r <= t3_nxt[32];
    xr11_r   <= xr10_r;
    n11_r    <= n10_r;
    p6_r     <= 62'(xr11_r) * 62'(t3m_11_r);
    sg12_r   <= n11_r ^ t3n_11_r;
    out_sin  <= sg12_r ? -$signed(r6_nxt) : $signed(r6_nxt);
  end

endmodule

FILE: rtl/eqo_isqrt.sv
// ----------------------------------------------------------------------------
// eqo_isqrt
// Pipelined floor square root, one result bit per stage, with a side word
// carried along.
// ----------------------------------------------------------------------------
module eqo_isqrt #(
  parameter int AUX_W = eqo_pkg::NUM_W
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_vld,
  input  logic [eqo_pkg::V_W-1:0]   in_val,
  input  logic [AUX_W-1:0]          in_aux,
  output logic                      out_vld,
  output logic [eqo_pkg::R_W-1:0]   out_root,
  output logic [AUX_W-1:0]          out_aux
);

  localparam int N = eqo_pkg::R_W;
  localparam int W = eqo_pkg::V_W;

  logic [W-1:0]     v_r   [0:N-1];
  logic [W-1:0]     rt_r  [0:N-1];
  logic [AUX_W-1:0] aux_r [0:N-1];
  logic [N-1:0]     vld_r;

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam logic [W-1:0] BIT = {{(W-1){1'b0}}, 1'b1} << (W - 2 - 2 * k);
    logic [W-1:0]     v_p, rt_p, sum_nxt, v_nxt, rt_nxt;
    logic [AUX_W-1:0] aux_p;
    logic             vld_p;
    if (k == 0) begin : g_first
      assign v_p   = in_val;
      assign rt_p  = '0;
      assign aux_p = in_aux;
      assign vld_p = in_vld;
    end else begin : g_next
      assign v_p   = v_r[k-1];
      assign rt_p  = rt_r[k-1];
      assign aux_p = aux_r[k-1];
      assign vld_p = vld_r[k-1];
    end
    always_comb begin
      sum_nxt = rt_p + BIT;
      if (v_p >= sum_nxt) begin
        v_nxt  = v_p - sum_nxt;
        rt_nxt = (rt_p >> 1) + BIT;
      end else begin
        v_nxt  = v_p;
        rt_nxt = rt_p >> 1;
      end
    end
    always_ff @(posedge clk) begin
      v_r[k]   <= v_nxt;
      rt_r[k]  <= rt_nxt;
      aux_r[k] <= aux_p;
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_p;
      end
    end
  end

  assign out_vld  = vld_r[N-1];
  assign out_root = rt_r[N-1][eqo_pkg::R_W-1:0];
  assign out_aux  = aux_r[N-1];

endmodule

FILE: rtl/eqo_div.sv
// ----------------------------------------------------------------------------
// eqo_div
// Pipelined rounded division of the projection by the vector length,
// one quotient bit per stage, saturated to one and zero for a zero length.
// ----------------------------------------------------------------------------
module eqo_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_vld,
  input  logic signed [eqo_pkg::NUM_W-1:0]  in_num,
  input  logic [eqo_pkg::R_W-1:0]           in_den,
  output logic                              out_vld,
  output logic                              out_neg,
  output logic [eqo_pkg::RAT_W-1:0]         out_mag
);

  localparam int N    = eqo_pkg::Q_W;
  localparam int RW   = eqo_pkg::NUM_W;
  localparam int DW   = eqo_pkg::R_W;

  logic [RW-1:0] nmag_nxt;
  logic [RW-1:0] rem0_r;
  logic [DW-1:0] den0_r;
  logic          neg0_r, zero0_r, vld0_r;

  logic [RW-1:0] rem_r  [0:N-1];
  logic [DW-1:0] den_r  [0:N-1];
  logic [N-1:0]  q_r    [0:N-1];
  logic [N-1:0]  neg_r, zero_r, vld_r;

  assign nmag_nxt = in_num[RW-1] ? RW'(-in_num) : RW'(in_num);

  always_ff @(posedge clk) begin
    rem0_r  <= nmag_nxt + RW'(in_den >> 1);
    den0_r  <= in_den;
    neg0_r  <= in_num[RW-1];
    zero0_r <= (in_den == '0);
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else begin
      vld0_r <= in_vld;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [RW-1:0] rem_p, dsh_nxt, rem_nxt;
    logic [DW-1:0] den_p;
    logic [N-1:0]  q_p, q_nxt;
    logic          neg_p, zero_p, vld_p;
    if (k == 0) begin : g_first
      assign rem_p  = rem0_r;
      assign den_p  = den0_r;
      assign q_p    = '0;
      assign neg_p  = neg0_r;
      assign zero_p = zero0_r;
      assign vld_p  = vld0_r;
    end else begin : g_next
      assign rem_p  = rem_r[k-1];
      assign den_p  = den_r[k-1];
      assign q_p    = q_r[k-1];
      assign neg_p  = neg_r[k-1];
      assign zero_p = zero_r[k-1];
      assign vld_p  = vld_r[k-1];
    end
    always_comb begin
      dsh_nxt = RW'(den_p) << (N - 1 - k);
      rem_nxt = rem_p;
      q_nxt   = q_p;
      if (rem_p >= dsh_nxt) begin
        rem_nxt = rem_p - dsh_nxt;
        q_nxt[N-1-k] = 1'b1;
      end
    end
    always_ff @(posedge clk) begin
      rem_r[k]  <= rem_nxt;
      den_r[k]  <= den_p;
      q_r[k]    <= q_nxt;
      neg_r[k]  <= neg_p;
      zero_r[k] <= zero_p;
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_p;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_neg <= neg_r[N-1];
    if (zero_r[N-1]) begin
      out_mag <= '0;
    end else if (q_r[N-1] > N'(eqo_pkg::Q28_ONE)) begin
      out_mag <= eqo_pkg::Q28_ONE;
    end else begin
      out_mag <= q_r[N-1][eqo_pkg::RAT_W-1:0];
    end
    if (!rst_n) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= vld_r[N-1];
    end
  end

endmodule

FILE: rtl/eqo_channel.sv
// ----------------------------------------------------------------------------
// eqo_channel
// One oscillator channel: sine and cosine of phase and shape, offset and
// scale, projection, length, division and output level.
// ----------------------------------------------------------------------------
module eqo_channel #(
  parameter int SAMPLE_BITS = eqo_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_vld,
  input  logic signed [eqo_pkg::ANG_W-1:0] in_angle,
  input  eqo_pkg::chan_cfg_t               cfg,
  output logic                             out_vld,
  output logic [SAMPLE_BITS-1:0]           out_sample
);

  localparam int SH = 44 - SAMPLE_BITS;
  localparam logic [44:0] RND = 45'd1 << (SH - 1);
  localparam logic [44:0] HI  = (45'd1 << (SAMPLE_BITS - 1)) - 45'd1;
  localparam int MW = eqo_pkg::MAG_W;
  localparam int VW = eqo_pkg::V_W;

  logic signed [eqo_pkg::ANG_W-1:0] ang_c, sh_s, sh_c;
  logic signed [eqo_pkg::SIN_W-1:0] s_w, c_w, ss_w, sc_w;
  logic [eqo_pkg::SIN_LAT-1:0]      vq_r;

  logic signed [15:0] off_s, off_c;
  logic [31:0]        smag_nxt;

  logic signed [32:0] x28_r;
  logic [47:0]        py_r;
  logic               ys1_r, v1_r;
  logic signed [eqo_pkg::SIN_W-1:0] sc1_r, ss1_r;

  logic [32:0] x28m_nxt;
  logic [35:0] y28m_nxt;
  logic [MW-1:0] xm_r, ym_r;
  logic          xn2_r, yn2_r, v2_r;
  logic signed [eqo_pkg::SIN_W-1:0] sc2_r, ss2_r;

  logic [31:0] scm_nxt, ssm_nxt;
  logic [VW-1:0] xx_r, yy_r, pxs_r, pys_r;
  logic          xs3_r, ys3_r, v3_r;

  logic signed [eqo_pkg::NUM_W-1:0] tx_nxt, ty_nxt;
  logic [VW-1:0]                    v4_r;
  logic signed [eqo_pkg::NUM_W-1:0] num4_r;
  logic                             v4v_r;

  logic                             sq_vld;
  logic [eqo_pkg::R_W-1:0]          sq_root;
  logic [eqo_pkg::NUM_W-1:0]        sq_num;

  logic                             dv_vld, dv_neg;
  logic [eqo_pkg::RAT_W-1:0]        dv_mag;

  logic signed [15:0] lvl_s;
  logic [15:0]        lmag_nxt;
  logic [44:0]        po_r;
  logic               pon_r, pov_r;
  logic [44:0]        om_nxt;

  assign ang_c = in_angle + eqo_pkg::QUARTER_TURN;
  assign sh_s  = $signed({{2{cfg.shape[15]}}, cfg.shape, 16'd0});
  assign sh_c  = sh_s + eqo_pkg::QUARTER_TURN;

  eqo_sin u_sin (.clk(clk), .in_angle(in_angle), .out_sin(s_w));
  eqo_sin u_cos (.clk(clk), .in_angle(ang_c),    .out_sin(c_w));
  eqo_sin u_shs (.clk(clk), .in_angle(sh_s),     .out_sin(ss_w));
  eqo_sin u_shc (.clk(clk), .in_angle(sh_c),     .out_sin(sc_w));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vq_r <= '0;
    end else begin
      vq_r <= {vq_r[eqo_pkg::SIN_LAT-2:0], in_vld};
    end
  end

  always_comb begin
    off_s = $signed(cfg.offset);
    off_c = off_s;
    if (off_s < -16'sd16384) begin
      off_c = -16'sd16384;
    end else if (off_s > 16'sd16384) begin
      off_c = 16'sd16384;
    end
    smag_nxt = s_w[eqo_pkg::SIN_W-1] ? 32'(-s_w) : 32'(s_w);
    x28m_nxt = x28_r[32] ? 33'(-x28_r) : 33'(x28_r);
    y28m_nxt = 36'((py_r + 48'd2048) >> 12);
    scm_nxt  = sc2_r[eqo_pkg::SIN_W-1] ? 32'(-sc2_r) : 32'(sc2_r);
    ssm_nxt  = ss2_r[eqo_pkg::SIN_W-1] ? 32'(-ss2_r) : 32'(ss2_r);
    tx_nxt   = xs3_r ? -$signed({2'b00, pxs_r}) : $signed({2'b00, pxs_r});
    ty_nxt   = ys3_r ? -$signed({2'b00, pys_r}) : $signed({2'b00, pys_r});
    lvl_s    = $signed(cfg.level);
    lmag_nxt = lvl_s[15] ? 16'(-lvl_s) : 16'(lvl_s);
    om_nxt   = (po_r + RND) >> SH;
  end

  always_ff @(posedge clk) begin
    // offset, scale
    x28_r <= $signed({{3{off_c[15]}}, off_c, 14'd0}) + $signed({c_w[31], c_w});
    py_r  <= 48'(cfg.scale) * 48'(smag_nxt);
    ys1_r <= s_w[eqo_pkg::SIN_W-1];
    sc1_r <= sc_w;
    ss1_r <= ss_w;
    // Q28 to Q24
    xm_r  <= MW'((x28m_nxt + 33'd8) >> 4);
    ym_r  <= MW'((y28m_nxt + 36'd8) >> 4);
    xn2_r <= x28_r[32];
    yn2_r <= ys1_r;
    sc2_r <= sc1_r;
    ss2_r <= ss1_r;
    // squares and projection terms
    xx_r  <= VW'(60'(xm_r) * 60'(xm_r));
    yy_r  <= VW'(60'(ym_r) * 60'(ym_r));
    pxs_r <= VW'(62'(xm_r) * 62'(scm_nxt));
    pys_r <= VW'(62'(ym_r) * 62'(ssm_nxt));
    xs3_r <= xn2_r ^ sc2_r[eqo_pkg::SIN_W-1];
    ys3_r <= yn2_r ^ ss2_r[eqo_pkg::SIN_W-1];
    // length squared and numerator
    v4_r   <= xx_r + yy_r;
    num4_r <= tx_nxt + ty_nxt;
    // level
    po_r  <= 45'(dv_mag) * 45'(lmag_nxt);
    pon_r <= dv_neg ^ lvl_s[15];
    if (pon_r) begin
      out_sample <= SAMPLE_BITS'(-om_nxt);
    end else if (om_nxt > HI) begin
      out_sample <= SAMPLE_BITS'(HI);
    end else begin
      out_sample <= SAMPLE_BITS'(om_nxt);
    end
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4v_r   <= 1'b0;
      pov_r   <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      v1_r    <= vq_r[eqo_pkg::SIN_LAT-1];
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      v4v_r   <= v3_r;
      pov_r   <= dv_vld;
      out_vld <= pov_r;
    end
  end

  eqo_isqrt #(.AUX_W(eqo_pkg::NUM_W)) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (v4v_r),
    .in_val   (v4_r),
    .in_aux   (num4_r),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_aux  (sq_num)
  );

  eqo_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (sq_vld),
    .in_num  ($signed(sq_num)),
    .in_den  (sq_root),
    .out_vld (dv_vld),
    .out_neg (dv_neg),
    .out_mag (dv_mag)
  );

endmodule

FILE: rtl/ellipse_quadrature_oscillator.sv
// ----------------------------------------------------------------------------
// ellipse_quadrature_oscillator
// Two-channel ellipse quadrature oscillator with configuration registers.
// ----------------------------------------------------------------------------
// One phase item is taken in every clock cycle (busy stays low). Each item
// gives one X and Y sample pair on out_strobe; it passes the pipelined sine
// units (13 stages), the one-bit-a-stage square root (29 stages) and the
// divider (33 stages). Results are shown for a single cycle and the receiver
// cannot stall them. Write configuration only while no item is in flight.
module ellipse_quadrature_oscillator #(
  parameter int PHASE_BITS  = eqo_pkg::PHASE_BITS_DEF,
  parameter int SAMPLE_BITS = eqo_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [PHASE_BITS-1:0]  in_phase_turn,
  output logic                   out_strobe,
  output logic [SAMPLE_BITS-1:0] out_x_sample,
  output logic [SAMPLE_BITS-1:0] out_y_sample,
  input  logic                   cfg_we,
  input  logic [2:0]             cfg_index,
  input  logic [15:0]            cfg_wdata
);

  logic [15:0] level_gain_r, x_offset_r, y_offset_r, x_scale_r, y_scale_r;
  logic [15:0] x_shape_r, y_shape_r;

  logic                             acc;
  logic signed [eqo_pkg::ANG_W-1:0] ang_x, ang_y;
  eqo_pkg::chan_cfg_t               cfg_x, cfg_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_gain_r <= 16'd32767;
      x_offset_r   <= 16'd0;
      y_offset_r   <= 16'd0;
      x_scale_r    <= 16'd4096;
      y_scale_r    <= 16'd4096;
      x_shape_r    <= 16'd0;
      y_shape_r    <= 16'd0;
    end else if (cfg_we) begin
      case (eqo_pkg::cfg_idx_t'(cfg_index))
        eqo_pkg::IDX_LEVEL_GAIN: level_gain_r <= cfg_wdata;
        eqo_pkg::IDX_X_OFFSET:   x_offset_r   <= cfg_wdata;
        eqo_pkg::IDX_Y_OFFSET:   y_offset_r   <= cfg_wdata;
        eqo_pkg::IDX_X_SCALE:    x_scale_r    <= cfg_wdata;
        eqo_pkg::IDX_Y_SCALE:    y_scale_r    <= cfg_wdata;
        eqo_pkg::IDX_X_SHAPE:    x_shape_r    <= cfg_wdata;
        eqo_pkg::IDX_Y_SHAPE:    y_shape_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign busy  = 1'b0;
  assign acc   = start && !busy;
  assign ang_x = $signed({2'b00, in_phase_turn, {(32 - PHASE_BITS){1'b0}}});
  assign ang_y = ang_x - eqo_pkg::QUARTER_TURN;

  assign cfg_x = '{level: level_gain_r, offset: x_offset_r, scale: x_scale_r,
                   shape: x_shape_r};
  assign cfg_y = '{level: level_gain_r, offset: y_offset_r, scale: y_scale_r,
                   shape: y_shape_r};

  eqo_channel #(.SAMPLE_BITS(SAMPLE_BITS)) u_chan_x (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (acc),
    .in_angle   (ang_x),
    .cfg        (cfg_x),
    .out_vld    (out_strobe),
    .out_sample (out_x_sample)
  );

  eqo_channel #(.SAMPLE_BITS(SAMPLE_BITS)) u_chan_y (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (acc),
    .in_angle   (ang_y),
    .cfg        (cfg_y),
    .out_vld    (),
    .out_sample (out_y_sample)
  );

endmodule

FILE: test/ellipse_quadrature_oscillator_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ellipse_quadrature_oscillator_checker
// Watches the phase, result and register ports of the oscillator. It keeps
// its own copy of the registers and predicts the X and Y samples of each
// accepted phase in fixed point. Each strobed result is compared with the
// oldest prediction.
// ----------------------------------------------------------------------------
module ellipse_quadrature_oscillator_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [15:0] in_phase_turn,
  input  logic        out_strobe,
  input  logic [15:0] out_x_sample,
  input  logic [15:0] out_y_sample,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  output int          fail_count,
  output int          samples_due
);

  localparam longint ONE_TURN  = 64'sd4294967296;
  localparam longint HALF      = 64'sd2147483648;
  localparam longint QUARTER   = 64'sd1073741824;
  localparam longint ONE_Q28   = 64'sd268435456;
  localparam longint RAD_SCALE = 64'sd1686629713;
  localparam longint C_SIX     = 64'sd44739243;
  localparam longint C_120     = 64'sd2236962;
  localparam longint C_5040    = 64'sd53261;

  typedef struct {
    logic [15:0] x_sample;
    logic [15:0] y_sample;
  } sample_pair_t;

  logic [15:0] level_gain, x_offset, y_offset, x_scale, y_scale, x_shape, y_shape;
  sample_pair_t pending_pairs[$];

  function automatic bit [63:0] abs64(longint a);
    return a < 0 ? 64'(-a) : 64'(a);
  endfunction

  function automatic longint round_mul(longint a, longint b, int sh);
    bit neg;
    bit [63:0] p;
    neg = (a < 0) != (b < 0);
    p = abs64(a) * abs64(b);
    if (sh > 0) p = (p + (64'd1 << (sh - 1))) >> sh;
    return neg ? -longint'(p) : longint'(p);
  endfunction

  function automatic bit [63:0] floor_sqrt(bit [63:0] v);
    bit [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint sine_q28(longint s);
    bit neg;
    longint xr, x2, t, r;
    while (s > HALF) s -= ONE_TURN;
    while (s < -HALF) s += ONE_TURN;
    neg = s < 0;
    xr = longint'((abs64(s) * 64'(RAD_SCALE) + (64'd1 << 31)) >> 32);
    x2 = round_mul(xr, xr, 28);
    t = C_120 - round_mul(x2, C_5040, 28);
    t = -C_SIX + round_mul(x2, t, 28);
    t = ONE_Q28 + round_mul(x2, t, 28);
    r = round_mul(xr, t, 28);
    return neg ? -r : r;
  endfunction

  function automatic longint project_q28(longint ph, logic [15:0] off_r,
                                         logic [15:0] scale_r, logic [15:0] shape_r);
    longint s, c, ang, ss, sc, off, x, y, num;
    bit [63:0] den, q;
    s = sine_q28(ph);
    c = sine_q28(ph + QUARTER);
    ang = longint'($signed(shape_r)) * 65536;
    ss = sine_q28(ang);
    sc = sine_q28(ang + QUARTER);
    off = longint'($signed(off_r));
    if (off < -16384) off = -16384;
    if (off > 16384) off = 16384;
    x = round_mul(off * 16384 + c, 1, 4);
    y = round_mul(round_mul(longint'(scale_r), s, 12), 1, 4);
    den = floor_sqrt(abs64(x) * abs64(x) + abs64(y) * abs64(y));
    if (den == 0) return 0;
    num = x * sc + y * ss;
    q = (abs64(num) + den / 2) / den;
    if (q > 64'(ONE_Q28)) q = 64'(ONE_Q28);
    return num < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [15:0] level_sample(longint r);
    longint v;
    v = round_mul(r, longint'($signed(level_gain)), 28);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  always @(posedge clk) begin
    sample_pair_t exp_pair;
    longint t;
    if (!rst_n) begin
      level_gain <= 16'd32767;
      x_offset   <= 16'd0;
      y_offset   <= 16'd0;
      x_scale    <= 16'd4096;
      y_scale    <= 16'd4096;
      x_shape    <= 16'd0;
      y_shape    <= 16'd0;
      pending_pairs.delete();
    end else begin
      if (out_strobe) begin
        if (pending_pairs.size() == 0) begin
          $error("unexpected sample pair x=%0d y=%0d",
                 $signed(out_x_sample), $signed(out_y_sample));
          fail_count++;
        end else begin
          exp_pair = pending_pairs.pop_front();
          if (out_x_sample !== exp_pair.x_sample) begin
            $error("x_sample: expected %0d, got %0d",
                   $signed(exp_pair.x_sample), $signed(out_x_sample));
            fail_count++;
          end
          if (out_y_sample !== exp_pair.y_sample) begin
            $error("y_sample: expected %0d, got %0d",
                   $signed(exp_pair.y_sample), $signed(out_y_sample));
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        t = longint'(in_phase_turn) << 16;
        exp_pair.x_sample = level_sample(project_q28(t, x_offset, x_scale, x_shape));
        exp_pair.y_sample = level_sample(project_q28(t - QUARTER, y_offset, y_scale, y_shape));
        pending_pairs.push_back(exp_pair);
      end
      if (cfg_we) begin
        case (eqo_pkg::cfg_idx_t'(cfg_index))
          eqo_pkg::IDX_LEVEL_GAIN: level_gain <= cfg_wdata;
          eqo_pkg::IDX_X_OFFSET:   x_offset   <= cfg_wdata;
          eqo_pkg::IDX_Y_OFFSET:   y_offset   <= cfg_wdata;
          eqo_pkg::IDX_X_SCALE:    x_scale    <= cfg_wdata;
          eqo_pkg::IDX_Y_SCALE:    y_scale    <= cfg_wdata;
          eqo_pkg::IDX_X_SHAPE:    x_shape    <= cfg_wdata;
          eqo_pkg::IDX_Y_SHAPE:    y_shape    <= cfg_wdata;
          default: ;
        endcase
      end
    end
    samples_due = pending_pairs.size();
  end

endmodule

FILE: test/ellipse_quadrature_oscillator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ellipse_quadrature_oscillator_test
// Drives phases into the oscillator under a series of register settings, from
// reset values to extremes and random values, with random gaps between items
// in most runs. A checker beside it predicts and compares every sample pair.
// ----------------------------------------------------------------------------
module ellipse_quadrature_oscillator_test;

  localparam int SETTLE_CYCLES = 90;
  localparam int CYCLE_LIMIT   = 300000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [15:0] in_phase_turn;
  logic        out_strobe;
  logic [15:0] out_x_sample;
  logic [15:0] out_y_sample;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_wdata;
  int          fail_count;
  int          samples_due;
  int          cycle_count;

  ellipse_quadrature_oscillator u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_phase_turn(in_phase_turn),
    .out_strobe   (out_strobe),
    .out_x_sample (out_x_sample),
    .out_y_sample (out_y_sample),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  ellipse_quadrature_oscillator_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_phase_turn(in_phase_turn),
    .out_strobe   (out_strobe),
    .out_x_sample (out_x_sample),
    .out_y_sample (out_y_sample),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .samples_due  (samples_due)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ellipse_quadrature_oscillator_test failed");
      $finish;
    end
  end

  task automatic write_reg(eqo_pkg::cfg_idx_t idx, logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic write_all(logic [15:0] lvl, logic [15:0] xo, logic [15:0] yo,
                           logic [15:0] xs, logic [15:0] ys,
                           logic [15:0] xh, logic [15:0] yh);
    write_reg(eqo_pkg::IDX_LEVEL_GAIN, lvl);
    write_reg(eqo_pkg::IDX_X_OFFSET, xo);
    write_reg(eqo_pkg::IDX_Y_OFFSET, yo);
    write_reg(eqo_pkg::IDX_X_SCALE, xs);
    write_reg(eqo_pkg::IDX_Y_SCALE, ys);
    write_reg(eqo_pkg::IDX_X_SHAPE, xh);
    write_reg(eqo_pkg::IDX_Y_SHAPE, yh);
  endtask

  // hold start until the item is taken, then idle for a random gap if gaps_on
  task automatic send_phase(logic [15:0] ph, bit gaps_on);
    int r, gap;
    start         <= 1'b1;
    in_phase_turn <= ph;
    do @(posedge clk); while (busy);
    r = $urandom_range(0, 99);
    gap = 0;
    if (gaps_on) gap = (r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (samples_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_phase();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'($urandom_range(0, 3) * 16384 + $urandom_range(0, 2) - 1);
    return 16'($urandom);
  endfunction

  task automatic random_run(int n);
    bit gaps_on;
    gaps_on = $urandom_range(0, 3) != 0;
    repeat (n) send_phase(rand_phase(), gaps_on);
    drain();
  endtask

  initial begin
    logic [15:0] directed_phases[] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                                       16'hFFFF, 16'h0001, 16'h7FFF, 16'h8001,
                                       16'h3FFF, 16'h4001, 16'hBFFF, 16'hC001,
                                       16'h2000, 16'hAAAA, 16'h5555};
    rst_n         = 1'b0;
    start         = 1'b0;
    in_phase_turn = 16'd0;
    cfg_we        = 1'b0;
    cfg_index     = 3'd0;
    cfg_wdata     = 16'd0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_phases[i]) send_phase(directed_phases[i], 1'b0);
    drain();
    random_run(60);

    // zero length: offset -1 with no sine leaves nothing at phase zero
    write_all(16'h8000, 16'hC000, 16'h4000, 16'h0000, 16'h0000, 16'h8000, 16'h7FFF);
    foreach (directed_phases[i]) send_phase(directed_phases[i], 1'b0);
    drain();
    random_run(60);

    // offsets beyond one get clamped
    write_all(16'h7FFF, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001, 16'h4000, 16'hC000);
    random_run(70);
    write_all(16'h8000, 16'h4000, 16'hC000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
    random_run(70);
    write_all(16'h0000, 16'h1234, 16'h8765, 16'h1000, 16'h2000, 16'h0001, 16'hFFFF);
    random_run(40);

    repeat (7) begin
      write_all(16'($urandom), 16'($urandom_range(0, 32768) - 16384),
                16'($urandom), 16'($urandom), 16'($urandom_range(0, 8192)),
                16'($urandom), 16'($urandom));
      random_run(60);
    end

    if (fail_count == 0) begin
      $display("ellipse_quadrature_oscillator_test passed");
    end else begin
      $display("ellipse_quadrature_oscillator_test failed");
    end
    $finish;
  end

endmodule
